// ----- sv/cel_pkg.sv -----
`default_nettype none

package cel_pkg;

  // Longest expansion of one input byte: six digits, tab, then up to four bytes
  localparam int unsigned RUN_MAX = 11;
  localparam int unsigned RUN_W   = $clog2(RUN_MAX + 1);
  localparam int unsigned IDX_W   = $clog2(RUN_MAX);

  // Configuration register map (word index)
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned PADDR_W   = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_ENDS    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_TABS    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_NONPRT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_NUM_NONBLANK = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NUM_ALL      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SQUEEZE      = 3'd5;

  // Character constants
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_I      = 8'd73;
  localparam logic [7:0] CH_M      = 8'd77;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CARET_OFS = 8'd64;

  localparam logic [23:0] BCD_ONE = 24'h000001;
  localparam logic [23:0] BCD_MAX = 24'h999999;

  typedef struct packed {
    logic show_ends;
    logic show_tabs;
    logic show_nonprt;
    logic num_nonblank;
    logic num_all;
    logic squeeze;
  } cfg_t;

  typedef struct packed {
    logic [23:0] line_bcd;
    logic        at_start;
    logic [1:0]  nl_run;
  } state_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_W-1:0]        len;
  } run_t;

endpackage

`default_nettype wire

// ----- sv/cel_expand.sv -----
`default_nettype none

// Expands one text byte into its output run and computes the next state.
module cel_expand (
  input  wire logic [7:0]    ch,
  input  wire cel_pkg::cfg_t cfg,
  input  wire cel_pkg::state_t st,
  output cel_pkg::run_t      run,
  output cel_pkg::state_t    st_nxt
);

  logic                       is_nl;
  logic                       squeezed;
  logic                       numbered;
  logic                       lead;
  logic                       is_ctl;
  logic [3:0]                 dig;
  logic [3:0][7:0]            tail;
  logic [2:0]                 tail_len;
  logic [6:0][7:0]            prefix;
  logic [23:0]                bcd_inc;
  logic                       carry;

  // Classification
  always_comb begin
    is_nl    = (ch == cel_pkg::CH_NL);
    squeezed = is_nl && (st.nl_run >= 2'd2);
    is_ctl   = ch inside {[8'd0:8'd8], [8'd11:8'd31], [8'd127:8'd159]};
    if (is_nl) begin
      numbered = st.at_start && cfg.num_all && !cfg.num_nonblank && !squeezed;
    end else begin
      numbered = st.at_start && (cfg.num_all || cfg.num_nonblank);
    end
  end

  // Six-digit right-aligned number, then a tab
  always_comb begin
    lead = 1'b1;
    dig  = '0;
    for (int k = 5; k >= 0; k--) begin
      dig  = st.line_bcd[4*k +: 4];
      lead = lead && (dig == 4'd0) && (k != 0);
      prefix[5-k] = lead ? cel_pkg::CH_SPACE : {4'h3, dig};
    end
    prefix[6] = cel_pkg::CH_TAB;
  end

  // Byte part of the run
  always_comb begin
    tail     = '0;
    tail_len = 3'd1;
    if (is_nl) begin
      if (cfg.show_ends) begin
        tail[0]  = cel_pkg::CH_DOLLAR;
        tail[1]  = cel_pkg::CH_NL;
        tail_len = 3'd2;
      end else begin
        tail[0] = cel_pkg::CH_NL;
      end
    end else if (cfg.show_nonprt && is_ctl) begin
      if (ch > 8'd127) begin
        tail[0]  = cel_pkg::CH_M;
        tail[1]  = cel_pkg::CH_DASH;
        tail[2]  = cel_pkg::CH_CARET;
        tail[3]  = ch - cel_pkg::CARET_OFS;
        tail_len = 3'd4;
      end else begin
        tail[0]  = cel_pkg::CH_CARET;
        tail[1]  = (ch >= cel_pkg::CH_SPACE) ? ch - cel_pkg::CARET_OFS
                                             : ch + cel_pkg::CARET_OFS;
        tail_len = 3'd2;
      end
    end else if (ch == cel_pkg::CH_TAB && cfg.show_tabs) begin
      tail[0]  = cel_pkg::CH_CARET;
      tail[1]  = cel_pkg::CH_I;
      tail_len = 3'd2;
    end else begin
      tail[0] = ch;
    end
  end

  // Assemble the run
  always_comb begin
    run.bytes = '0;
    if (numbered) begin
      for (int i = 0; i < 7; i++) run.bytes[i] = prefix[i];
      for (int j = 0; j < 4; j++) run.bytes[7+j] = tail[j];
      run.len = cel_pkg::RUN_W'(tail_len) + cel_pkg::RUN_W'(7);
    end else begin
      for (int j = 0; j < 4; j++) run.bytes[j] = tail[j];
      run.len = cel_pkg::RUN_W'(tail_len);
    end
    if (squeezed) run.len = '0;
  end

  // BCD increment, saturating at 999999
  always_comb begin
    bcd_inc = st.line_bcd;
    carry   = 1'b1;
    for (int k = 0; k < 6; k++) begin
      if (carry) begin
        if (st.line_bcd[4*k +: 4] < 4'd9) begin
          bcd_inc[4*k +: 4] = st.line_bcd[4*k +: 4] + 4'd1;
          carry = 1'b0;
        end else begin
          bcd_inc[4*k +: 4] = 4'd0;
        end
      end
    end
    if (st.line_bcd == cel_pkg::BCD_MAX) bcd_inc = st.line_bcd;
  end

  // Next state
  always_comb begin
    st_nxt = st;
    if (numbered) st_nxt.line_bcd = bcd_inc;
    if (is_nl) begin
      if (!squeezed) begin
        st_nxt.at_start = 1'b1;
        if (cfg.squeeze) st_nxt.nl_run = st.nl_run + 2'd1;
      end
    end else begin
      st_nxt.at_start = 1'b0;
      st_nxt.nl_run   = 2'd0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/caret_escape_line_numberer_top.sv -----
`default_nettype none

// Channel  | Ports                                   | Beat
// ---------+-----------------------------------------+---------------------------
// input    | in_valid, in_stall, in_byte             | one text byte
// output   | out_valid, out_stall, out_byte,         | one formatted byte,
//          | out_last_of_run                         | last of its run marked
// config   | psel, penable, pwrite, paddr, pwdata,   | one register, APB-style
//          | prdata, pready                          |
//
// An input beat is expanded in the cycle it is accepted into a run register
// of up to 11 bytes; while the output is not stalled, the run drains one byte
// per cycle into the output register, and bytes that each yield one output
// byte sustain one beat per cycle. A squeezed newline yields no output byte.
// The next input is taken in the cycle the current run's last byte moves out.
// Synchronous active-low reset sets line number 1, line start, all modes off.
module caret_escape_line_numberer_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_byte,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [7:0]                      out_byte,
  output logic                            out_last_of_run,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cel_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  cel_pkg::cfg_t   cfg_r;
  cel_pkg::state_t st_r;
  cel_pkg::state_t st_nxt;
  cel_pkg::run_t   run_nxt;

  logic [cel_pkg::RUN_MAX-1:0][7:0] run_bytes_r;
  logic [cel_pkg::RUN_W-1:0]        run_len_r;
  logic [cel_pkg::IDX_W-1:0]        run_idx_r;
  logic                             run_valid_r;
  logic                             out_valid_r;
  logic [7:0]                       out_byte_r;
  logic                             out_last_r;

  logic                             out_free;
  logic                             run_move;
  logic                             run_at_last;
  logic                             in_accept;
  logic                             cfg_write;
  logic [cel_pkg::REG_IDX_W-1:0]    reg_idx;

  cel_expand u_expand (
    .ch     (in_byte),
    .cfg    (cfg_r),
    .st     (st_r),
    .run    (run_nxt),
    .st_nxt (st_nxt)
  );

  // Handshake
  assign out_free    = !out_valid_r || !out_stall;
  assign run_move    = run_valid_r && out_free;
  assign run_at_last = (cel_pkg::RUN_W'(run_idx_r) + cel_pkg::RUN_W'(1)) == run_len_r;
  assign in_stall    = run_valid_r && !(run_move && run_at_last);
  assign in_accept   = in_valid && !in_stall;

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

  // Configuration port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[cel_pkg::PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (reg_idx)
      cel_pkg::REG_SHOW_ENDS:    prdata[0] = cfg_r.show_ends;
      cel_pkg::REG_SHOW_TABS:    prdata[0] = cfg_r.show_tabs;
      cel_pkg::REG_SHOW_NONPRT:  prdata[0] = cfg_r.show_nonprt;
      cel_pkg::REG_NUM_NONBLANK: prdata[0] = cfg_r.num_nonblank;
      cel_pkg::REG_NUM_ALL:      prdata[0] = cfg_r.num_all;
      cel_pkg::REG_SQUEEZE:      prdata[0] = cfg_r.squeeze;
      default:                   prdata    = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        cel_pkg::REG_SHOW_ENDS:    cfg_r.show_ends    <= pwdata[0];
        cel_pkg::REG_SHOW_TABS:    cfg_r.show_tabs    <= pwdata[0];
        cel_pkg::REG_SHOW_NONPRT:  cfg_r.show_nonprt  <= pwdata[0];
        cel_pkg::REG_NUM_NONBLANK: cfg_r.num_nonblank <= pwdata[0];
        cel_pkg::REG_NUM_ALL:      cfg_r.num_all      <= pwdata[0];
        cel_pkg::REG_SQUEEZE:      cfg_r.squeeze      <= pwdata[0];
        default:                   cfg_r              <= cfg_r;
      endcase
    end
  end

  // Text state advances when a beat is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.line_bcd <= cel_pkg::BCD_ONE;
      st_r.at_start <= 1'b1;
      st_r.nl_run   <= 2'd0;
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  // Run register: loaded on accept, drained one byte per cycle while the output is not stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      run_idx_r   <= '0;
    end else if (in_accept) begin
      run_valid_r <= (run_nxt.len != '0);
      run_idx_r   <= '0;
    end else if (run_move) begin
      if (run_at_last) begin
        run_valid_r <= 1'b0;
      end
      run_idx_r <= run_idx_r + cel_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      run_bytes_r <= run_nxt.bytes;
      run_len_r   <= run_nxt.len;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= run_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (run_move) begin
      out_byte_r <= run_bytes_r[run_idx_r];
      out_last_r <= run_at_last;
    end
  end

endmodule

`default_nettype wire
